### hdl/rss_pkg.sv
package rss_pkg;

  // mode state codes
  typedef enum logic [2:0] {
    MS_RESET    = 3'd0,
    MS_REL      = 3'd1,
    MS_HALF     = 3'd2,
    MS_FULL     = 3'd3,
    MS_STARTREC = 3'd4,
    MS_REC      = 3'd5,
    MS_STOPREC  = 3'd6
  } mode_e;

  // configuration register indexes
  localparam logic [1:0] CFG_MODULE_SELECT   = 2'd0;
  localparam logic [1:0] CFG_CAPTURE_CONTEXT = 2'd1;
  localparam logic [1:0] CFG_SYNC_ENABLE     = 2'd2;
  localparam logic [1:0] CFG_SWITCH_KIND     = 2'd3;
  localparam int unsigned CFG_DATA_W = 4;

  // module select codes
  localparam logic [3:0] SEL_NORMAL  = 4'd1;
  localparam logic [3:0] SEL_QUICK   = 4'd2;
  localparam logic [3:0] SEL_BURST   = 4'd3;
  localparam logic [3:0] SEL_BRACKET = 4'd4;
  localparam logic [3:0] SEL_ZOOM    = 4'd5;
  localparam logic [3:0] SEL_VIDEO   = 4'd6;

  // switch kinds
  localparam logic [1:0] SW_SINGLE = 2'd0;
  localparam logic [1:0] SW_DOUBLE = 2'd1;
  localparam logic [1:0] SW_PULSE  = 2'd2;

  // remote levels
  localparam logic [1:0] LV_REL  = 2'd0;
  localparam logic [1:0] LV_HALF = 2'd1;
  localparam logic [1:0] LV_FULL = 2'd2;

  // key commands
  localparam logic [1:0] KEY_NONE     = 2'd0;
  localparam logic [1:0] KEY_PRESS    = 2'd1;
  localparam logic [1:0] KEY_REL      = 2'd2;
  localparam logic [1:0] KEY_REL_ONLY = 2'd3;

  // zoom commands
  localparam logic [2:0] ZOOM_NONE    = 3'd0;
  localparam logic [2:0] ZOOM_OUT_ONE = 3'd1;
  localparam logic [2:0] ZOOM_IN_ONE  = 3'd2;
  localparam logic [2:0] ZOOM_OUT_MAX = 3'd3;
  localparam logic [2:0] ZOOM_IN_MAX  = 3'd4;

  // zoom pulse counts
  localparam logic [2:0] PLS_STEP_OUT = 3'd1;
  localparam logic [2:0] PLS_STEP_IN  = 3'd2;
  localparam logic [2:0] PLS_SHOOT    = 3'd3;
  localparam logic [2:0] PLS_FULL_OUT = 3'd4;
  localparam logic [2:0] PLS_FULL_IN  = 3'd5;

  localparam logic [31:0] BRACKET_TIMEOUT_MS = 32'd5000;

  typedef struct packed {
    logic [3:0] module_select;
    logic       capture_context;
    logic       sync_enable;
    logic [1:0] switch_kind;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  remote_level;
    logic [2:0]  pulse_count;
    logic        shoot_done;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic [1:0] half_key;
    logic [1:0] full_key;
    logic       start_shoot;
    logic       sync_wait;
    logic [2:0] zoom_cmd;
    logic       bracket_step;
    logic       bracket_reset;
    logic       state_fault;
  } result_t;

endpackage

### hdl/rss_stream_if.sv
interface rss_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/remote_shutter_sequencer.sv
// Remote shutter sequencer: one poll transaction in, one result transaction out.
// A poll is first captured in an input register, then the selected control
// module (normal, sync normal, quick, burst, bracket, zoom or video) updates
// the mode state and bracket stamp and loads the result register when that
// register is empty or being drained. One poll is taken every cycle while the
// output is not stalled; the mode state loop closes through a single register,
// which sets that rate. While a result waits in the output register one more
// poll can sit in the input register.
// Writing any configuration register returns the mode state to reset; the
// bracket stamp is kept. Configure only while no poll is in flight.
module remote_shutter_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  rss_stream_if.sink                      poll_i,
  rss_stream_if.source                    result_o
);

  // configuration registers
  rss_pkg::cfg_t cfg_q;

  // input register stage
  logic           in_valid_q;
  rss_pkg::poll_t in_q;

  // block state
  rss_pkg::mode_e mode_q;
  rss_pkg::mode_e mode_d;
  logic [31:0]    stamp_q;
  logic [31:0]    stamp_d;

  // result register stage
  logic             out_valid_q;
  rss_pkg::result_t out_q;
  rss_pkg::result_t res_d;

  logic out_free;
  logic advance;

  // the result register can load when empty or being drained this cycle
  assign out_free = !out_valid_q || result_o.ready;
  // the captured poll moves through the step logic into the result register
  assign advance  = in_valid_q && out_free;

  assign poll_i.ready     = !in_valid_q || advance;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  rss_step u_step (
    .cfg_i   (cfg_q),
    .mode_i  (mode_q),
    .stamp_i (stamp_q),
    .poll_i  (in_q),
    .mode_o  (mode_d),
    .stamp_o (stamp_d),
    .res_o   (res_d)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rss_pkg::CFG_MODULE_SELECT:   cfg_q.module_select   <= cfg_data_i[3:0];
        rss_pkg::CFG_CAPTURE_CONTEXT: cfg_q.capture_context <= cfg_data_i[0];
        rss_pkg::CFG_SYNC_ENABLE:     cfg_q.sync_enable     <= cfg_data_i[0];
        rss_pkg::CFG_SWITCH_KIND:     cfg_q.switch_kind     <= cfg_data_i[1:0];
        default:                      cfg_q                 <= cfg_q;
      endcase
    end
  end

  // mode state and bracket stamp; a config write restarts the mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rss_pkg::MS_RESET;
      stamp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= rss_pkg::MS_RESET;
      end else if (advance) begin
        mode_q <= mode_d;
      end
      if (advance) begin
        stamp_q <= stamp_d;
      end
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_valid_q <= poll_i.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (poll_i.valid && poll_i.ready) begin
      in_q <= poll_i.payload;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

endmodule

### hdl/rss_step.sv
module rss_step (
  input  rss_pkg::cfg_t    cfg_i,
  input  rss_pkg::mode_e   mode_i,
  input  logic [31:0]      stamp_i,
  input  rss_pkg::poll_t   poll_i,
  output rss_pkg::mode_e   mode_o,
  output logic [31:0]      stamp_o,
  output rss_pkg::result_t res_o
);

  logic [1:0]  lv;
  logic        pressed;
  logic        bad;
  logic        k_one;
  logic        k_two;
  logic [31:0] elapsed;
  logic        timed_out;

  assign lv        = poll_i.remote_level;
  assign pressed   = (lv == rss_pkg::LV_HALF) || (lv == rss_pkg::LV_FULL);
  assign bad       = !pressed && (lv != rss_pkg::LV_REL);
  assign k_one     = (cfg_i.switch_kind == rss_pkg::SW_SINGLE);
  assign k_two     = (cfg_i.switch_kind == rss_pkg::SW_DOUBLE)
                  || (cfg_i.switch_kind == rss_pkg::SW_PULSE);
  assign elapsed   = poll_i.now_ms - stamp_i;
  assign timed_out = (stamp_i != '0) && (elapsed > rss_pkg::BRACKET_TIMEOUT_MS);

  always_comb begin
    res_o   = '0;
    mode_o  = mode_i;
    stamp_o = stamp_i;
    if (cfg_i.capture_context) begin
      // video table: normal, quick and video selections run video
      if (cfg_i.module_select == rss_pkg::SEL_NORMAL ||
          cfg_i.module_select == rss_pkg::SEL_QUICK ||
          cfg_i.module_select == rss_pkg::SEL_VIDEO) begin
        unique case (mode_i)
          rss_pkg::MS_RESET: mode_o = rss_pkg::MS_REL;
          rss_pkg::MS_REL: begin
            if (bad) res_o.state_fault = 1'b1;
            else if (pressed) begin
              res_o.full_key = rss_pkg::KEY_PRESS;
              mode_o = rss_pkg::MS_STARTREC;
            end
          end
          rss_pkg::MS_STARTREC: begin
            if (bad) res_o.state_fault = 1'b1;
            else if (!pressed) begin
              res_o.full_key = rss_pkg::KEY_REL;
              mode_o = rss_pkg::MS_REC;
            end
          end
          rss_pkg::MS_REC: begin
            if (bad) res_o.state_fault = 1'b1;
            else if (pressed) begin
              res_o.full_key = rss_pkg::KEY_PRESS;
              mode_o = rss_pkg::MS_STOPREC;
            end
          end
          rss_pkg::MS_STOPREC: begin
            if (bad) res_o.state_fault = 1'b1;
            else if (!pressed) begin
              res_o.full_key = rss_pkg::KEY_REL;
              mode_o = rss_pkg::MS_REL;
            end
          end
          default: res_o.state_fault = 1'b1;
        endcase
      end
    end else begin
      unique case (cfg_i.module_select)
        rss_pkg::SEL_NORMAL: begin
          if (cfg_i.sync_enable) begin
            unique case (mode_i)
              rss_pkg::MS_RESET: mode_o = rss_pkg::MS_REL;
              rss_pkg::MS_REL: begin
                if (lv == rss_pkg::LV_HALF) begin
                  if (k_one) begin
                    res_o.start_shoot = 1'b1;
                    res_o.sync_wait   = 1'b1;
                    mode_o = rss_pkg::MS_HALF;
                  end else if (k_two) begin
                    res_o.half_key = rss_pkg::KEY_PRESS;
                    mode_o = rss_pkg::MS_HALF;
                  end
                end else if (bad) res_o.state_fault = 1'b1;
              end
              rss_pkg::MS_HALF: begin
                if (lv == rss_pkg::LV_FULL) begin
                  if (k_one) mode_o = rss_pkg::MS_FULL;
                  else if (k_two) begin
                    res_o.sync_wait = 1'b1;
                    res_o.full_key  = rss_pkg::KEY_PRESS;
                    mode_o = rss_pkg::MS_FULL;
                  end
                end else if (lv == rss_pkg::LV_REL) begin
                  if (k_one) begin
                    if (poll_i.shoot_done) mode_o = rss_pkg::MS_REL;
                  end else if (k_two) begin
                    res_o.half_key = rss_pkg::KEY_REL;
                    mode_o = rss_pkg::MS_REL;
                  end
                end else if (lv != rss_pkg::LV_HALF) res_o.state_fault = 1'b1;
              end
              rss_pkg::MS_FULL: begin
                if (lv == rss_pkg::LV_REL) begin
                  if (k_one) begin
                    if (poll_i.shoot_done) mode_o = rss_pkg::MS_REL;
                  end else if (k_two) begin
                    res_o.full_key = rss_pkg::KEY_REL;
                    res_o.half_key = rss_pkg::KEY_REL;
                    mode_o = rss_pkg::MS_REL;
                  end
                end else if (bad) res_o.state_fault = 1'b1;
              end
              default: res_o.state_fault = 1'b1;
            endcase
          end else begin
            unique case (mode_i)
              rss_pkg::MS_RESET: begin
                res_o.full_key = rss_pkg::KEY_REL;
                res_o.half_key = rss_pkg::KEY_REL;
                mode_o = rss_pkg::MS_REL;
              end
              rss_pkg::MS_REL: begin
                if (lv == rss_pkg::LV_HALF) begin
                  res_o.half_key = rss_pkg::KEY_PRESS;
                  mode_o = rss_pkg::MS_HALF;
                end else if (lv == rss_pkg::LV_FULL) begin
                  res_o.half_key = rss_pkg::KEY_PRESS;
                  res_o.full_key = rss_pkg::KEY_PRESS;
                  mode_o = rss_pkg::MS_FULL;
                end else if (bad) res_o.state_fault = 1'b1;
              end
              rss_pkg::MS_HALF: begin
                if (lv == rss_pkg::LV_REL) begin
                  res_o.half_key = rss_pkg::KEY_REL;
                  mode_o = rss_pkg::MS_REL;
                end else if (lv == rss_pkg::LV_FULL) begin
                  res_o.full_key = rss_pkg::KEY_PRESS;
                  mode_o = rss_pkg::MS_FULL;
                end else if (bad) res_o.state_fault = 1'b1;
              end
              rss_pkg::MS_FULL: begin
                if (lv == rss_pkg::LV_REL) begin
                  res_o.full_key = rss_pkg::KEY_REL;
                  res_o.half_key = rss_pkg::KEY_REL;
                  mode_o = rss_pkg::MS_REL;
                end else if (lv == rss_pkg::LV_HALF) begin
                  res_o.full_key = rss_pkg::KEY_REL;
                  mode_o = rss_pkg::MS_HALF;
                end else if (bad) res_o.state_fault = 1'b1;
              end
              default: res_o.state_fault = 1'b1;
            endcase
          end
        end
        rss_pkg::SEL_QUICK: begin
          unique case (mode_i)
            rss_pkg::MS_RESET: mode_o = rss_pkg::MS_REL;
            rss_pkg::MS_REL: begin
              if (pressed) begin
                res_o.start_shoot = 1'b1;
                mode_o = rss_pkg::MS_FULL;
              end else if (bad) res_o.state_fault = 1'b1;
            end
            rss_pkg::MS_FULL: begin
              if (lv == rss_pkg::LV_REL && poll_i.shoot_done) mode_o = rss_pkg::MS_REL;
            end
            default: res_o.state_fault = 1'b1;
          endcase
        end
        rss_pkg::SEL_BURST: begin
          unique case (mode_i)
            rss_pkg::MS_RESET: mode_o = rss_pkg::MS_REL;
            rss_pkg::MS_REL: begin
              if (pressed) begin
                res_o.start_shoot = 1'b1;
                mode_o = rss_pkg::MS_HALF;
              end else if (bad) res_o.state_fault = 1'b1;
            end
            rss_pkg::MS_HALF: begin
              if (poll_i.shoot_done) mode_o = rss_pkg::MS_REL;
            end
            default: res_o.state_fault = 1'b1;
          endcase
        end
        rss_pkg::SEL_BRACKET: begin
          unique case (mode_i)
            rss_pkg::MS_RESET: mode_o = rss_pkg::MS_REL;
            rss_pkg::MS_REL: begin
              if (timed_out) begin
                res_o.bracket_reset = 1'b1;
                stamp_o = '0;
              end
              if (lv == rss_pkg::LV_HALF) begin
                res_o.half_key = rss_pkg::KEY_PRESS;
                mode_o = rss_pkg::MS_HALF;
              end else if (lv == rss_pkg::LV_FULL) begin
                res_o.full_key = rss_pkg::KEY_PRESS;
                mode_o  = rss_pkg::MS_FULL;
                stamp_o = poll_i.now_ms;
              end else if (bad) res_o.state_fault = 1'b1;
            end
            rss_pkg::MS_HALF: begin
              if (lv == rss_pkg::LV_REL) begin
                res_o.half_key = rss_pkg::KEY_REL;
                mode_o = rss_pkg::MS_REL;
              end else if (lv == rss_pkg::LV_FULL) begin
                res_o.full_key = rss_pkg::KEY_PRESS;
                mode_o  = rss_pkg::MS_FULL;
                stamp_o = poll_i.now_ms;
              end else if (bad) res_o.state_fault = 1'b1;
            end
            rss_pkg::MS_FULL: begin
              if (lv == rss_pkg::LV_REL) begin
                res_o.full_key     = rss_pkg::KEY_REL_ONLY;
                res_o.half_key     = rss_pkg::KEY_REL;
                res_o.bracket_step = 1'b1;
                mode_o = rss_pkg::MS_REL;
              end else if (lv == rss_pkg::LV_HALF) begin
                res_o.full_key     = rss_pkg::KEY_REL_ONLY;
                res_o.bracket_step = 1'b1;
                mode_o = rss_pkg::MS_HALF;
              end else if (bad) res_o.state_fault = 1'b1;
            end
            default: res_o.state_fault = 1'b1;
          endcase
        end
        rss_pkg::SEL_ZOOM: begin
          // foreign states are ignored here
          if (mode_i == rss_pkg::MS_RESET) mode_o = rss_pkg::MS_REL;
          else if (mode_i == rss_pkg::MS_REL) begin
            case (poll_i.pulse_count)
              rss_pkg::PLS_STEP_OUT: res_o.zoom_cmd = rss_pkg::ZOOM_OUT_ONE;
              rss_pkg::PLS_STEP_IN:  res_o.zoom_cmd = rss_pkg::ZOOM_IN_ONE;
              rss_pkg::PLS_SHOOT: begin
                res_o.start_shoot = 1'b1;
                mode_o = rss_pkg::MS_FULL;
              end
              rss_pkg::PLS_FULL_OUT: res_o.zoom_cmd = rss_pkg::ZOOM_OUT_MAX;
              rss_pkg::PLS_FULL_IN:  res_o.zoom_cmd = rss_pkg::ZOOM_IN_MAX;
              default: res_o.zoom_cmd = rss_pkg::ZOOM_NONE;
            endcase
          end else if (mode_i == rss_pkg::MS_FULL) begin
            if (poll_i.shoot_done) mode_o = rss_pkg::MS_REL;
          end
        end
        default: res_o = '0;
      endcase
    end
  end

endmodule

### hdl/rss_checker.sv
module rss_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             poll_ready,
  input logic             result_valid,
  input logic             result_ready,
  input rss_pkg::result_t result_payload
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid && !result_ready |=> result_valid && $stable(result_payload))
    else $error("stalled result changed");

  // an empty output register never blocks polls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid |-> poll_ready)
    else $error("poll blocked while output empty");

  // an error result carries no command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid && result_payload.state_fault |->
      result_payload.half_key == rss_pkg::KEY_NONE &&
      result_payload.full_key == rss_pkg::KEY_NONE &&
      !result_payload.start_shoot && !result_payload.sync_wait &&
      result_payload.zoom_cmd == rss_pkg::ZOOM_NONE && !result_payload.bracket_step)
    else $error("command issued with state fault");

  // bracket step and reset come from different states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid |-> !(result_payload.bracket_step && result_payload.bracket_reset))
    else $error("bracket step and reset together");

endmodule

bind remote_shutter_sequencer rss_checker u_rss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .poll_ready     (poll_i.ready),
  .result_valid   (result_o.valid),
  .result_ready   (result_o.ready),
  .result_payload (result_o.payload)
);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // codes the package leaves out
  localparam logic [1:0]       LV_BAD     = 2'd3;
  localparam logic [1:0]       SW_UNKNOWN = 2'd3;
  localparam logic [3:0]       SEL_NONE   = 4'd0;
  localparam logic [3:0]       SEL_TOP    = 4'd15;
  localparam rss_pkg::result_t NO_ACTION  = '0;

  // random polls per phase, four phases
  localparam int unsigned PHASE_POLLS = 488;
  // receiver hold-off used to back the block up
  localparam int unsigned LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data;

  rss_stream_if #(.payload_t(rss_pkg::poll_t))   poll_if ();
  rss_stream_if #(.payload_t(rss_pkg::result_t)) res_if ();

  remote_shutter_sequencer DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .poll_i    (poll_if),
    .result_o  (res_if)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // a poll in flight, with an optional hand-typed expectation
  typedef struct {
    bit               pinned;
    rss_pkg::result_t want;
  } poll_pin_t;

  // one row of the directed table: a register write or a poll
  typedef struct {
    bit               is_cfg;
    logic [1:0]       idx;
    logic [3:0]       data;
    rss_pkg::poll_t   poll;
    bit               pinned;
    rss_pkg::result_t want;
  } vec_row_t;

  poll_pin_t        poll_pins[$];       // polls offered, oldest first
  rss_pkg::result_t pending_results[$]; // results owed by the block
  vec_row_t         vec_tab[$];
  int unsigned err_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req = 0;

  // shadow of the sequencer state
  rss_pkg::cfg_t  cur_cfg;
  rss_pkg::mode_e cur_mode;
  logic [31:0]    bracket_stamp;

  // ---------------------------------------------------------------------------
  // shutter sequencer model: one poll in, one result out, state updated
  // ---------------------------------------------------------------------------
  function automatic rss_pkg::result_t predict_poll(rss_pkg::poll_t p);
    rss_pkg::result_t r;
    logic [1:0]  lv;
    logic        pressed;
    logic        bad;
    logic        two;
    logic        one;
    logic [31:0] elapsed;
    r       = '0;
    lv      = p.remote_level;
    pressed = (lv == rss_pkg::LV_HALF) || (lv == rss_pkg::LV_FULL);
    bad     = (lv == LV_BAD);
    one     = (cur_cfg.switch_kind == rss_pkg::SW_SINGLE);
    two     = (cur_cfg.switch_kind == rss_pkg::SW_DOUBLE) ||
              (cur_cfg.switch_kind == rss_pkg::SW_PULSE);
    elapsed = p.now_ms - bracket_stamp;

    if (cur_cfg.capture_context) begin
      // video table: normal, quick and video slots all run video
      if (cur_cfg.module_select == rss_pkg::SEL_NORMAL ||
          cur_cfg.module_select == rss_pkg::SEL_QUICK ||
          cur_cfg.module_select == rss_pkg::SEL_VIDEO) begin
        case (cur_mode)
          rss_pkg::MS_RESET: cur_mode = rss_pkg::MS_REL;
          rss_pkg::MS_REL: begin
            if (bad) r.state_fault = 1'b1;
            else if (pressed) begin
              r.full_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_STARTREC;
            end
          end
          rss_pkg::MS_STARTREC: begin
            if (bad) r.state_fault = 1'b1;
            else if (!pressed) begin
              r.full_key = rss_pkg::KEY_REL; cur_mode = rss_pkg::MS_REC;
            end
          end
          rss_pkg::MS_REC: begin
            if (bad) r.state_fault = 1'b1;
            else if (pressed) begin
              r.full_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_STOPREC;
            end
          end
          rss_pkg::MS_STOPREC: begin
            if (bad) r.state_fault = 1'b1;
            else if (!pressed) begin
              r.full_key = rss_pkg::KEY_REL; cur_mode = rss_pkg::MS_REL;
            end
          end
          default: r.state_fault = 1'b1;
        endcase
      end
    end else begin
      case (cur_cfg.module_select)
        rss_pkg::SEL_NORMAL: begin
          if (!cur_cfg.sync_enable) begin
            case (cur_mode)
              rss_pkg::MS_RESET: begin
                r.full_key = rss_pkg::KEY_REL; r.half_key = rss_pkg::KEY_REL;
                cur_mode = rss_pkg::MS_REL;
              end
              rss_pkg::MS_REL: begin
                if (lv == rss_pkg::LV_HALF) begin
                  r.half_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_HALF;
                end else if (lv == rss_pkg::LV_FULL) begin
                  r.half_key = rss_pkg::KEY_PRESS; r.full_key = rss_pkg::KEY_PRESS;
                  cur_mode = rss_pkg::MS_FULL;
                end else if (lv != rss_pkg::LV_REL) r.state_fault = 1'b1;
              end
              rss_pkg::MS_HALF: begin
                if (lv == rss_pkg::LV_REL) begin
                  r.half_key = rss_pkg::KEY_REL; cur_mode = rss_pkg::MS_REL;
                end else if (lv == rss_pkg::LV_FULL) begin
                  r.full_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_FULL;
                end else if (lv != rss_pkg::LV_HALF) r.state_fault = 1'b1;
              end
              rss_pkg::MS_FULL: begin
                if (lv == rss_pkg::LV_REL) begin
                  r.full_key = rss_pkg::KEY_REL; r.half_key = rss_pkg::KEY_REL;
                  cur_mode = rss_pkg::MS_REL;
                end else if (lv == rss_pkg::LV_HALF) begin
                  r.full_key = rss_pkg::KEY_REL; cur_mode = rss_pkg::MS_HALF;
                end else if (lv != rss_pkg::LV_FULL) r.state_fault = 1'b1;
              end
              default: r.state_fault = 1'b1;
            endcase
          end else begin
            // sync handling, an unknown switch kind does nothing
            case (cur_mode)
              rss_pkg::MS_RESET: cur_mode = rss_pkg::MS_REL;
              rss_pkg::MS_REL: begin
                if (lv == rss_pkg::LV_HALF) begin
                  if (one) begin
                    r.start_shoot = 1'b1; r.sync_wait = 1'b1; cur_mode = rss_pkg::MS_HALF;
                  end else if (two) begin
                    r.half_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_HALF;
                  end
                end else if (bad) r.state_fault = 1'b1;
              end
              rss_pkg::MS_HALF: begin
                if (lv == rss_pkg::LV_FULL) begin
                  if (one) cur_mode = rss_pkg::MS_FULL;
                  else if (two) begin
                    r.sync_wait = 1'b1; r.full_key = rss_pkg::KEY_PRESS;
                    cur_mode = rss_pkg::MS_FULL;
                  end
                end else if (lv == rss_pkg::LV_REL) begin
                  if (one) begin
                    if (p.shoot_done) cur_mode = rss_pkg::MS_REL;
                  end else if (two) begin
                    r.half_key = rss_pkg::KEY_REL; cur_mode = rss_pkg::MS_REL;
                  end
                end else if (bad) r.state_fault = 1'b1;
              end
              rss_pkg::MS_FULL: begin
                if (lv == rss_pkg::LV_REL) begin
                  if (one) begin
                    if (p.shoot_done) cur_mode = rss_pkg::MS_REL;
                  end else if (two) begin
                    r.full_key = rss_pkg::KEY_REL; r.half_key = rss_pkg::KEY_REL;
                    cur_mode = rss_pkg::MS_REL;
                  end
                end else if (bad) r.state_fault = 1'b1;
              end
              default: r.state_fault = 1'b1;
            endcase
          end
        end
        rss_pkg::SEL_QUICK: begin
          case (cur_mode)
            rss_pkg::MS_RESET: cur_mode = rss_pkg::MS_REL;
            rss_pkg::MS_REL: begin
              if (pressed) begin r.start_shoot = 1'b1; cur_mode = rss_pkg::MS_FULL; end
              else if (bad) r.state_fault = 1'b1;
            end
            rss_pkg::MS_FULL:
              if (lv == rss_pkg::LV_REL && p.shoot_done) cur_mode = rss_pkg::MS_REL;
            default: r.state_fault = 1'b1;
          endcase
        end
        rss_pkg::SEL_BURST: begin
          case (cur_mode)
            rss_pkg::MS_RESET: cur_mode = rss_pkg::MS_REL;
            rss_pkg::MS_REL: begin
              if (pressed) begin r.start_shoot = 1'b1; cur_mode = rss_pkg::MS_HALF; end
              else if (bad) r.state_fault = 1'b1;
            end
            rss_pkg::MS_HALF: if (p.shoot_done) cur_mode = rss_pkg::MS_REL;
            default: r.state_fault = 1'b1;
          endcase
        end
        rss_pkg::SEL_BRACKET: begin
          case (cur_mode)
            rss_pkg::MS_RESET: cur_mode = rss_pkg::MS_REL;
            rss_pkg::MS_REL: begin
              // idle timeout, wrap-around difference
              if (bracket_stamp != 0 && elapsed > rss_pkg::BRACKET_TIMEOUT_MS) begin
                r.bracket_reset = 1'b1; bracket_stamp = '0;
              end
              if (lv == rss_pkg::LV_HALF) begin
                r.half_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_HALF;
              end else if (lv == rss_pkg::LV_FULL) begin
                r.full_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_FULL;
                bracket_stamp = p.now_ms;
              end else if (bad) r.state_fault = 1'b1;
            end
            rss_pkg::MS_HALF: begin
              if (lv == rss_pkg::LV_REL) begin
                r.half_key = rss_pkg::KEY_REL; cur_mode = rss_pkg::MS_REL;
              end else if (lv == rss_pkg::LV_FULL) begin
                r.full_key = rss_pkg::KEY_PRESS; cur_mode = rss_pkg::MS_FULL;
                bracket_stamp = p.now_ms;
              end else if (bad) r.state_fault = 1'b1;
            end
            rss_pkg::MS_FULL: begin
              if (lv == rss_pkg::LV_REL) begin
                r.full_key = rss_pkg::KEY_REL_ONLY; r.half_key = rss_pkg::KEY_REL;
                r.bracket_step = 1'b1; cur_mode = rss_pkg::MS_REL;
              end else if (lv == rss_pkg::LV_HALF) begin
                r.full_key = rss_pkg::KEY_REL_ONLY; r.bracket_step = 1'b1;
                cur_mode = rss_pkg::MS_HALF;
              end else if (bad) r.state_fault = 1'b1;
            end
            default: r.state_fault = 1'b1;
          endcase
        end
        rss_pkg::SEL_ZOOM: begin
          // foreign states pass silently here
          if (cur_mode == rss_pkg::MS_RESET) cur_mode = rss_pkg::MS_REL;
          else if (cur_mode == rss_pkg::MS_REL) begin
            case (p.pulse_count)
              rss_pkg::PLS_STEP_OUT: r.zoom_cmd = rss_pkg::ZOOM_OUT_ONE;
              rss_pkg::PLS_STEP_IN:  r.zoom_cmd = rss_pkg::ZOOM_IN_ONE;
              rss_pkg::PLS_SHOOT: begin
                r.start_shoot = 1'b1; cur_mode = rss_pkg::MS_FULL;
              end
              rss_pkg::PLS_FULL_OUT: r.zoom_cmd = rss_pkg::ZOOM_OUT_MAX;
              rss_pkg::PLS_FULL_IN:  r.zoom_cmd = rss_pkg::ZOOM_IN_MAX;
              default: ;
            endcase
          end else if (cur_mode == rss_pkg::MS_FULL) begin
            if (p.shoot_done) cur_mode = rss_pkg::MS_REL;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic rss_pkg::poll_t mk_poll(logic [1:0] lv, logic [2:0] pc, logic dn,
                                             logic [31:0] t);
    rss_pkg::poll_t p;
    p.remote_level = lv;
    p.pulse_count  = pc;
    p.shoot_done   = dn;
    p.now_ms       = t;
    return p;
  endfunction

  function automatic rss_pkg::result_t mk_res(logic [1:0] hk, logic [1:0] fk, logic ss,
                                              logic sw, logic [2:0] zc, logic bs,
                                              logic br, logic iv);
    rss_pkg::result_t r;
    r.half_key      = hk;
    r.full_key      = fk;
    r.start_shoot   = ss;
    r.sync_wait     = sw;
    r.zoom_cmd      = zc;
    r.bracket_step  = bs;
    r.bracket_reset = br;
    r.state_fault   = iv;
    return r;
  endfunction

  // directed table rows
  function automatic void add_cfg(logic [1:0] idx, logic [3:0] data);
    vec_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    vec_tab.push_back(row);
  endfunction

  function automatic void add_poll(rss_pkg::poll_t p);
    vec_row_t row;
    row = '{default: '0};
    row.poll = p;
    vec_tab.push_back(row);
  endfunction

  function automatic void add_known(rss_pkg::poll_t p, rss_pkg::result_t want);
    vec_row_t row;
    row = '{default: '0};
    row.poll   = p;
    row.pinned = 1'b1;
    row.want   = want;
    vec_tab.push_back(row);
  endfunction

  // offer one poll transaction, returns in the step it is taken
  task automatic offer_poll(rss_pkg::poll_t p, bit pinned, rss_pkg::result_t want);
    poll_pin_t pin;
    while ($urandom_range(99) < src_idle_pct) begin
      poll_if.valid <= 1'b0;
      @(posedge clk);
    end
    pin.pinned = pinned;
    pin.want   = want;
    poll_pins.push_back(pin);
    poll_if.valid   <= 1'b1;
    poll_if.payload <= p;
    do @(posedge clk); while (!poll_if.ready);
  endtask

  // hold the sender until every owed result is out
  task automatic drain_results();
    poll_if.valid <= 1'b0;
    while (pending_results.size() != 0 || poll_pins.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle; any write resets the mode state
  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rss_pkg::CFG_MODULE_SELECT:   cur_cfg.module_select   = data;
      rss_pkg::CFG_CAPTURE_CONTEXT: cur_cfg.capture_context = data[0];
      rss_pkg::CFG_SYNC_ENABLE:     cur_cfg.sync_enable     = data[0];
      rss_pkg::CFG_SWITCH_KIND:     cur_cfg.switch_kind     = data[1:0];
      default: ;
    endcase
    cur_mode = rss_pkg::MS_RESET;
  endtask

  task automatic report(string fld, int unsigned want, int unsigned got);
    err_cnt++;
    if (err_cnt <= 100)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // input monitor: every accepted poll runs through the model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : poll_mon
    poll_pin_t        pin;
    rss_pkg::result_t want;
    if (rst_n && poll_if.valid && poll_if.ready) begin
      pin  = poll_pins.pop_front();
      want = predict_poll(poll_if.payload);
      // hand-typed rows take precedence
      if (pin.pinned) want = pin.want;
      pending_results.push_back(want);
    end
  end

  // ---------------------------------------------------------------------------
  // output checker: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_chk
    rss_pkg::result_t want;
    rss_pkg::result_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 100) $display("%0t: result with none expected, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.half_key !== want.half_key) report("half_key", want.half_key, got.half_key);
        if (got.full_key !== want.full_key) report("full_key", want.full_key, got.full_key);
        if (got.start_shoot !== want.start_shoot)
          report("start_shoot", want.start_shoot, got.start_shoot);
        if (got.sync_wait !== want.sync_wait)
          report("sync_wait", want.sync_wait, got.sync_wait);
        if (got.zoom_cmd !== want.zoom_cmd) report("zoom_cmd", want.zoom_cmd, got.zoom_cmd);
        if (got.bracket_step !== want.bracket_step)
          report("bracket_step", want.bracket_step, got.bracket_step);
        if (got.bracket_reset !== want.bracket_reset)
          report("bracket_reset", want.bracket_reset, got.bracket_reset);
        if (got.state_fault !== want.state_fault)
          report("state_fault", want.state_fault, got.state_fault);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : sink_ctl
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed table, then four phases of random polls
  // ---------------------------------------------------------------------------
  initial begin : stim
    int unsigned phase;
    int unsigned placed;
    int unsigned seg;
    int unsigned pick;
    logic [1:0]  lvl_walk;
    logic [1:0]  lv;
    logic [31:0] clock_ms;
    logic [3:0]  sel;
    logic        ctx;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    poll_if.valid   = 1'b0;
    poll_if.payload = '0;
    cur_cfg         = '0;
    cur_mode        = rss_pkg::MS_RESET;
    bracket_stamp   = '0;
    lvl_walk        = rss_pkg::LV_REL;
    clock_ms        = '0;

    // no module after reset: nothing happens
    add_known(mk_poll(rss_pkg::LV_FULL, 3'd7, 1'b1, 32'hFFFF_FFFF), NO_ACTION);
    // plain normal module
    add_cfg(rss_pkg::CFG_MODULE_SELECT, rss_pkg::SEL_NORMAL);
    add_known(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_REL, rss_pkg::KEY_REL, 0, 0, rss_pkg::ZOOM_NONE, 0, 0, 0));
    add_known(mk_poll(rss_pkg::LV_HALF, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_PRESS, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 0));
    add_known(mk_poll(LV_BAD, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 1));
    add_known(mk_poll(rss_pkg::LV_FULL, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_PRESS, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 0));
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0));
    // sync handling, one press switch
    add_cfg(rss_pkg::CFG_SYNC_ENABLE, 4'd1);
    add_known(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0), NO_ACTION);
    add_known(mk_poll(rss_pkg::LV_HALF, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 1, 1, rss_pkg::ZOOM_NONE,
                     0, 0, 0));
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0));
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b1, 32'd0));
    // unknown switch kind takes no action
    add_cfg(rss_pkg::CFG_SWITCH_KIND, {2'b00, SW_UNKNOWN});
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0));
    add_known(mk_poll(rss_pkg::LV_HALF, 3'd0, 1'b0, 32'd0), NO_ACTION);
    // bracketing: step, timeout exactly at the limit, then one past it
    add_cfg(rss_pkg::CFG_MODULE_SELECT, rss_pkg::SEL_BRACKET);
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd1));
    add_known(mk_poll(rss_pkg::LV_FULL, 3'd0, 1'b0, 32'd100),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_PRESS, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 0));
    add_known(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd200),
              mk_res(rss_pkg::KEY_REL, rss_pkg::KEY_REL_ONLY, 0, 0, rss_pkg::ZOOM_NONE,
                     1, 0, 0));
    add_known(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd5100), NO_ACTION);
    add_known(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd5101),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 1, 0));
    // zoom: every pulse command
    add_cfg(rss_pkg::CFG_MODULE_SELECT, rss_pkg::SEL_ZOOM);
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0));
    add_known(mk_poll(rss_pkg::LV_REL, rss_pkg::PLS_STEP_OUT, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_OUT_ONE,
                     0, 0, 0));
    add_known(mk_poll(rss_pkg::LV_REL, rss_pkg::PLS_STEP_IN, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_IN_ONE,
                     0, 0, 0));
    add_known(mk_poll(rss_pkg::LV_REL, rss_pkg::PLS_FULL_OUT, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_OUT_MAX,
                     0, 0, 0));
    add_known(mk_poll(rss_pkg::LV_REL, rss_pkg::PLS_FULL_IN, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_IN_MAX,
                     0, 0, 0));
    add_known(mk_poll(rss_pkg::LV_REL, rss_pkg::PLS_SHOOT, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 1, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 0));
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b1, 32'd0));
    // video table
    add_cfg(rss_pkg::CFG_CAPTURE_CONTEXT, 4'd1);
    add_cfg(rss_pkg::CFG_MODULE_SELECT, rss_pkg::SEL_VIDEO);
    add_poll(mk_poll(rss_pkg::LV_REL, 3'd0, 1'b0, 32'd0));
    add_known(mk_poll(rss_pkg::LV_HALF, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_PRESS, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 0));
    add_known(mk_poll(LV_BAD, 3'd0, 1'b0, 32'd0),
              mk_res(rss_pkg::KEY_NONE, rss_pkg::KEY_NONE, 0, 0, rss_pkg::ZOOM_NONE,
                     0, 0, 1));
    // top select code runs no module
    add_cfg(rss_pkg::CFG_MODULE_SELECT, SEL_TOP);
    add_known(mk_poll(rss_pkg::LV_HALF, 3'd0, 1'b0, 32'd0), NO_ACTION);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling on either side
    foreach (vec_tab[i]) begin
      if (vec_tab[i].is_cfg) write_reg(vec_tab[i].idx, vec_tab[i].data);
      else offer_poll(vec_tab[i].poll, vec_tab[i].pinned, vec_tab[i].want);
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
        default: begin src_idle_pct = 38; snk_stall_pct = 38; end
      endcase
      placed = 0;
      while (placed < PHASE_POLLS) begin
        // new setting, mostly a live module in its own table
        pick = $urandom_range(99);
        if (pick < 75) begin
          ctx = 1'b0;
          sel = 4'($urandom_range(5, 1));
        end else if (pick < 90) begin
          ctx = 1'b1;
          case ($urandom_range(2))
            0: sel = rss_pkg::SEL_NORMAL;
            1: sel = rss_pkg::SEL_QUICK;
            default: sel = rss_pkg::SEL_VIDEO;
          endcase
        end else begin
          ctx = 1'($urandom_range(1));
          sel = 4'($urandom_range(15));
        end
        write_reg(rss_pkg::CFG_MODULE_SELECT, sel);
        write_reg(rss_pkg::CFG_CAPTURE_CONTEXT, {3'b000, ctx});
        write_reg(rss_pkg::CFG_SYNC_ENABLE, 4'($urandom_range(1)));
        if ($urandom_range(9) == 0) write_reg(rss_pkg::CFG_SWITCH_KIND, {2'b00, SW_UNKNOWN});
        else write_reg(rss_pkg::CFG_SWITCH_KIND, 4'($urandom_range(2)));

        // back the block up: long receiver hold while polls keep coming
        if (phase == 2 && placed == 0) hold_req = LONG_HOLD;

        seg = $urandom_range(60, 20);
        for (int j = 0; j < seg && placed < PHASE_POLLS; j++) begin
          // remote level walks between release, half and full
          if ($urandom_range(99) < 40) lvl_walk = 2'($urandom_range(2));
          lv = ($urandom_range(99) < 5) ? LV_BAD : lvl_walk;
          // time mostly creeps, sometimes jumps past or onto the timeout
          pick = $urandom_range(99);
          if (pick < 70) clock_ms += 32'($urandom_range(400));
          else if (pick < 85) clock_ms += 32'($urandom_range(7000, 3000));
          else if (pick < 92) clock_ms = bracket_stamp + rss_pkg::BRACKET_TIMEOUT_MS +
                                         32'($urandom_range(1));
          else if (pick < 97) clock_ms = $urandom();
          else clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(3000));
          offer_poll(mk_poll(lv, 3'($urandom_range(7)), 1'($urandom_range(99) < 60),
                             clock_ms), 1'b0, NO_ACTION);
          placed++;
        end
      end
    end

    // wait out every owed result, then idle on to catch strays
    drain_results();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
